>>> hdl/defalu_pkg.sv
// ============================================================================
// defalu_pkg
// Shared types, operation codes and constants of the extended-float ALU.
// ============================================================================
package defalu_pkg;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_NEG   = 4'd3,
        OP_ABS   = 4'd4,
        OP_RND   = 4'd5,
        OP_CMP   = 4'd6,
        OP_FIX   = 4'd7,
        OP_LOAD  = 4'd8,
        OP_LOADS = 4'd9,
        OP_STORE = 4'd10
    } op_t;

    localparam logic signed [7:0] ZERO_EXP = -8'sd128;
    localparam logic [31:0] TOP_BIT   = 32'h8000_0000;
    localparam logic [31:0] FRAC_MASK = 32'h7fff_ffff;

    // Item record: mode, both operands and the raw word
    typedef struct packed {
        logic [3:0]        mode;
        logic signed [7:0] ae;
        logic [31:0]       am;
        logic signed [7:0] be;
        logic [31:0]       bm;
        logic [31:0]       raw;
    } item_t;

    // Extended mantissa: 33-bit signed value, sign bit over the implied bit
    function automatic logic signed [32:0] ext_mant(input logic [31:0] m);
        ext_mant = {m[31], ~m[31], m[30:0]};
    endfunction

endpackage

>>> hdl/dsp_extended_float_alu_unit.sv
// ============================================================================
// dsp_extended_float_alu_unit
// Extended float ALU: add, sub, mul, neg, abs, round, compare, fix, load,
// short load and store, in a four-stage pipeline.
// ============================================================================
// Usage:
//   Input channel: valid/ready with mode, operands a and b and raw_word.
//   Output channel: valid/ready with res_exponent, res_mantissa, int_value,
//   compare_out and raw_out. All fields come with every result.
//   An item passes through the stage 1, 2, 3 and 4 valid registers in turn;
//   out_valid is the stage 4 valid bit, held until out_ready takes it.
//   Throughput: one item per cycle; each stage holds one item and moves on
//   when the stage after it is free or moving, so a stall on the output
//   backs up the pipe without losing or repeating anything.
//   Stage 1 aligns operands and forms the 25x25 product, stage 2 adds or
//   shifts the product, stage 3 finds the leading bit, stage 4 normalizes,
//   packs and saturates into the output register.
//   Reset clears all valid bits; the pipe is empty and in_ready is high.
// ============================================================================
module dsp_extended_float_alu_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         mode,
    input  logic signed [7:0]  a_exponent,
    input  logic [31:0]        a_mantissa,
    input  logic signed [7:0]  b_exponent,
    input  logic [31:0]        b_mantissa,
    input  logic [31:0]        raw_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [7:0]  res_exponent,
    output logic [31:0]        res_mantissa,
    output logic signed [31:0] int_value,
    output logic signed [1:0]  compare_out,
    output logic [31:0]        raw_out
);

    // Result kinds settled in stage 1
    typedef enum logic [1:0] {
        K_DIRECT = 2'd0,   // final fields already known
        K_SUM    = 2'd1,   // normalize a sum / mul / rnd value
        K_FIX    = 2'd2    // integer shift
    } kind_t;

    // ------------------------------------------------------------------
    // Handshake: each stage advances when the next is empty or advancing
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0 -> 1: decode, special cases, alignment, multiply
    // ------------------------------------------------------------------
    logic [1:0]         k1_next, k1_reg;
    logic signed [9:0]  e1_next, e1_reg;       // working exponent
    logic signed [33:0] x1_next, x1_reg;       // addend x
    logic signed [33:0] y1_next, y1_reg;       // addend y
    logic signed [49:0] p1_next, p1_reg;       // product
    logic               mul1_next, mul1_reg;
    logic signed [7:0]  de1_next, de1_reg;     // direct exponent
    logic [31:0]        dm1_next, dm1_reg;     // direct mantissa
    logic signed [1:0]  c1_next, c1_reg;
    logic [31:0]        st1_next, st1_reg;
    logic               neg1_next, neg1_reg;   // direct value needs negation
    logic [5:0]         fs1_next, fs1_reg;     // fix shift
    logic               fsat1_next, fsat1_reg;

    logic signed [32:0] ma, mb, mal, mbl;
    logic signed [8:0]  dexp;
    logic signed [8:0]  fsw;                   // full fix shift
    logic               az, bz, is_sub;
    logic signed [24:0] ta, tb;
    logic signed [1:0]  ca, cb;
    logic [15:0]        rs;

    always_comb
    begin
        ma   = defalu_pkg::ext_mant(a_mantissa);
        mb   = defalu_pkg::ext_mant(b_mantissa);
        az   = (a_exponent == defalu_pkg::ZERO_EXP);
        bz   = (b_exponent == defalu_pkg::ZERO_EXP);
        dexp = 9'(a_exponent) - 9'(b_exponent);
        fsw  = 9'sd31 - 9'(a_exponent);
        mal  = ma >>> (dexp < 0 ? 6'(-dexp) : 6'd0);
        mbl  = mb >>> (dexp > 0 ? 6'(dexp) : 6'd0);
        ta   = ma[32:8];
        tb   = mb[32:8];
        is_sub = (mode == defalu_pkg::OP_SUB);
        ca   = az ? 2'sd0 : (a_mantissa[31] ? -2'sd1 : 2'sd1);
        cb   = bz ? 2'sd0 : (b_exponent == defalu_pkg::ZERO_EXP ? 2'sd0 :
                             (b_mantissa[31] ? -2'sd1 : 2'sd1));
        rs   = raw_word[15:0];

        k1_next    = K_DIRECT;
        e1_next    = 10'(a_exponent);
        x1_next    = '0;
        y1_next    = '0;
        p1_next    = ta * tb;
        mul1_next  = 1'b0;
        de1_next   = defalu_pkg::ZERO_EXP;
        dm1_next   = '0;
        c1_next    = 2'sd0;
        st1_next   = '0;
        neg1_next  = 1'b0;
        fs1_next   = '0;
        fsat1_next = 1'b0;

        unique case (mode)
            defalu_pkg::OP_ADD, defalu_pkg::OP_SUB:
            begin
                if (is_sub && bz)
                begin
                    de1_next = a_exponent; dm1_next = a_mantissa;
                end
                else if (az)
                begin
                    de1_next = b_exponent; dm1_next = b_mantissa; neg1_next = is_sub;
                end
                else if (bz)
                begin
                    de1_next = a_exponent; dm1_next = a_mantissa;
                end
                else if (dexp >= 9'sd32)
                begin
                    de1_next = a_exponent; dm1_next = a_mantissa;
                end
                else if (dexp <= -9'sd32)
                begin
                    de1_next = b_exponent; dm1_next = b_mantissa; neg1_next = is_sub;
                end
                else
                begin
                    k1_next = K_SUM;
                    e1_next = (dexp > 0) ? 10'(a_exponent) : 10'(b_exponent);
                    x1_next = 34'(mal);
                    y1_next = is_sub ? -34'(mbl) : 34'(mbl);
                end
            end
            defalu_pkg::OP_MUL:
            begin
                if (!(az || bz))
                begin
                    k1_next   = K_SUM;
                    mul1_next = 1'b1;
                    e1_next   = 10'(a_exponent) + 10'(b_exponent);
                end
            end
            defalu_pkg::OP_NEG:
            begin
                if (!az)
                begin
                    de1_next = a_exponent; dm1_next = a_mantissa; neg1_next = 1'b1;
                end
            end
            defalu_pkg::OP_ABS:
            begin
                de1_next = a_exponent; dm1_next = a_mantissa;
                neg1_next = !az && a_mantissa[31];
            end
            defalu_pkg::OP_RND:
            begin
                if (az)
                begin
                    de1_next = a_exponent; dm1_next = a_mantissa;
                end
                else
                begin
                    k1_next = K_SUM;
                    x1_next = (34'(ma) + 34'sd128) & ~34'hff;
                end
            end
            defalu_pkg::OP_CMP:
            begin
                if (ca != cb)
                    c1_next = (ca > cb) ? 2'sd1 : -2'sd1;
                else if (ca == 2'sd0)
                    c1_next = 2'sd0;
                else if (a_exponent != b_exponent)
                    c1_next = ((a_exponent > b_exponent) == (ca > 0)) ? 2'sd1 : -2'sd1;
                else
                    c1_next = (ma > mb) ? 2'sd1 : ((ma < mb) ? -2'sd1 : 2'sd0);
            end
            defalu_pkg::OP_FIX:
            begin
                if (!az)
                begin
                    k1_next = K_FIX;
                    x1_next = 34'(ma);
                    if (a_exponent >= 8'sd31)
                        fsat1_next = 1'b1;
                    else
                        fs1_next = (fsw > 9'sd63) ? 6'd63 : 6'(fsw);
                end
            end
            defalu_pkg::OP_LOAD:
            begin
                if (raw_word[31:24] != 8'h80)
                begin
                    de1_next = raw_word[31:24]; dm1_next = {raw_word[23:0], 8'h00};
                end
            end
            defalu_pkg::OP_LOADS:
            begin
                if (!(rs[15:12] == 4'h8 && rs[11:0] == 12'h0))
                begin
                    de1_next = 8'(signed'(rs[15:12]));
                    dm1_next = {rs[11], rs[10:0], 20'h0};
                end
            end
            defalu_pkg::OP_STORE:
                st1_next = {a_exponent, a_mantissa[31:8]};
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            k1_reg <= k1_next; e1_reg <= e1_next; x1_reg <= x1_next;
            y1_reg <= y1_next; p1_reg <= p1_next; mul1_reg <= mul1_next;
            de1_reg <= de1_next; dm1_reg <= dm1_next; c1_reg <= c1_next;
            st1_reg <= st1_next; neg1_reg <= neg1_next; fs1_reg <= fs1_next;
            fsat1_reg <= fsat1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 -> 2: sum or product shift, direct negation, fix shift
    // ------------------------------------------------------------------
    logic [1:0]         k2_reg;
    logic signed [9:0]  e2_reg;
    logic signed [34:0] s2_next, s2_reg;
    logic signed [7:0]  de2_next, de2_reg;
    logic [31:0]        dm2_next, dm2_reg;
    logic signed [1:0]  c2_reg;
    logic [31:0]        st2_reg;
    logic signed [31:0] iv2_next, iv2_reg;
    logic signed [33:0] fsh;

    always_comb
    begin
        if (mul1_reg)
            s2_next = 35'(p1_reg >>> 15);
        else
            s2_next = 35'(x1_reg) + 35'(y1_reg);

        // exact negation with exponent adjustment and saturation
        de2_next = de1_reg;
        dm2_next = dm1_reg;
        if (neg1_reg)
        begin
            if (de1_reg == defalu_pkg::ZERO_EXP)
            begin
                de2_next = defalu_pkg::ZERO_EXP; dm2_next = '0;
            end
            else if ((dm1_reg & defalu_pkg::FRAC_MASK) != 32'h0)
                dm2_next = 32'h0 - dm1_reg;
            else if (dm1_reg == 32'h0)
            begin
                if (de1_reg == -8'sd127)
                begin
                    de2_next = defalu_pkg::ZERO_EXP; dm2_next = '0;
                end
                else
                begin
                    de2_next = de1_reg - 8'sd1; dm2_next = defalu_pkg::TOP_BIT;
                end
            end
            else if (de1_reg == 8'sd127)
                dm2_next = defalu_pkg::FRAC_MASK;
            else
            begin
                de2_next = de1_reg + 8'sd1; dm2_next = '0;
            end
        end

        fsh = x1_reg >>> fs1_reg;
        if (fsat1_reg)
            iv2_next = x1_reg[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            iv2_next = fsh[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            k2_reg <= k1_reg; e2_reg <= e1_reg; s2_reg <= s2_next;
            de2_reg <= de2_next; dm2_reg <= dm2_next; c2_reg <= c1_reg;
            st2_reg <= st1_reg; iv2_reg <= iv2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 -> 3: leading-bit position (redundant sign bits)
    // ------------------------------------------------------------------
    logic [1:0]         k3_reg;
    logic signed [9:0]  e3_reg;
    logic signed [34:0] s3_reg;
    logic [5:0]         lz3_next, lz3_reg;
    logic signed [7:0]  de3_reg;
    logic [31:0]        dm3_reg;
    logic signed [1:0]  c3_reg;
    logic [31:0]        st3_reg;
    logic signed [31:0] iv3_reg;
    logic               done;

    // count of consecutive bits equal to the sign, from bit 33 down
    always_comb
    begin
        lz3_next = 6'd0;
        done     = 1'b0;
        for (int i = 33; i >= 0; i--)
        begin
            if (!done && s2_reg[i] == s2_reg[34])
                lz3_next = lz3_next + 6'd1;
            else
                done = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            k3_reg <= k2_reg; e3_reg <= e2_reg; s3_reg <= s2_reg;
            lz3_reg <= lz3_next; de3_reg <= de2_reg; dm3_reg <= dm2_reg;
            c3_reg <= c2_reg; st3_reg <= st2_reg; iv3_reg <= iv2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 -> 4: normalize, saturate, select output fields
    // ------------------------------------------------------------------
    // Normalized value has sign at bit 34 and first differing bit at 31,
    // i.e. lz == 2. Right shifts (lz < 2) floor; left shifts are exact.
    logic signed [7:0]  re_next, re_reg;
    logic [31:0]        rm_next, rm_reg;
    logic signed [31:0] iv_next, iv_reg;
    logic signed [1:0]  c_next, c_reg;
    logic [31:0]        st_next, st_reg;
    logic signed [34:0] nm;
    logic signed [10:0] ne;
    logic               sum_zero;

    always_comb
    begin
        sum_zero = (s3_reg == 35'sd0);
        if (lz3_reg < 6'd2)
            nm = s3_reg >>> (6'd2 - lz3_reg);
        else
            nm = s3_reg <<< (lz3_reg - 6'd2);
        ne = 11'(e3_reg) + 11'sd2 - signed'({5'd0, lz3_reg});

        re_next = defalu_pkg::ZERO_EXP;
        rm_next = '0;
        iv_next = '0;
        c_next  = c3_reg;
        st_next = st3_reg;
        unique case (k3_reg)
            K_SUM:
            begin
                if (sum_zero || ne < -11'sd127)
                begin
                    re_next = defalu_pkg::ZERO_EXP; rm_next = '0;
                end
                else if (ne > 11'sd127)
                begin
                    re_next = 8'sd127;
                    rm_next = nm[34] ? 32'hffff_ffff : defalu_pkg::FRAC_MASK;
                end
                else
                begin
                    re_next = ne[7:0];
                    rm_next = nm[31:0] ^ defalu_pkg::TOP_BIT;
                end
            end
            K_FIX:    iv_next = iv3_reg;
            K_DIRECT:
            begin
                re_next = de3_reg; rm_next = dm3_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            re_reg <= re_next; rm_reg <= rm_next; iv_reg <= iv_next;
            c_reg <= c_next; st_reg <= st_next;
        end
    end

    assign res_exponent = re_reg;
    assign res_mantissa = rm_reg;
    assign int_value    = iv_reg;
    assign compare_out  = c_reg;
    assign raw_out      = st_reg;

`ifndef NO_ASSERTIONS
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_mantissa))
        else $error("result changed under stall");
    // compare never yields the unused code
    a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> compare_out != 2'b10)
        else $error("bad compare code");
    // a zero exponent comes with a zero mantissa from normalized results
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && $past(k3_reg == K_SUM && adv4) && res_exponent == defalu_pkg::ZERO_EXP
        |-> res_mantissa == 32'h0)
        else $error("nonzero mantissa on zero result");
    // input is taken whenever the output side is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("pipe stalled without back pressure");
`endif

endmodule
